FILE: hdl/fpps_pkg.sv
// Shared types and constants for the fixed-point PID step block.
`default_nettype none

package fpps_pkg;

	// Field and datapath widths
	localparam int GAIN_W  = 16;
	localparam int DATA_W  = 16;
	localparam int ERR_W   = 17;
	localparam int LIMIT_W = 24;
	localparam int INTEG_W = 32;
	localparam int PROD_W  = 34;
	localparam int SUM_W   = 36;
	localparam int IDX_W   = 3;

	// Reset values of the output window
	localparam logic signed [LIMIT_W-1:0] OUT_MAX_RST = 24'sh7FFF00;
	localparam logic signed [LIMIT_W-1:0] OUT_MIN_RST = 24'sh800000;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_P_GAIN  = 3'd0,
		REG_I_GAIN  = 3'd1,
		REG_D_GAIN  = 3'd2,
		REG_OUT_MAX = 3'd3,
		REG_OUT_MIN = 3'd4
	} reg_idx_t;

	// Configuration register set
	typedef struct packed {
		logic [GAIN_W-1:0]         p_gain;
		logic [GAIN_W-1:0]         i_gain;
		logic [GAIN_W-1:0]         d_gain;
		logic signed [LIMIT_W-1:0] out_max;
		logic signed [LIMIT_W-1:0] out_min;
	} cfg_t;

	// Products handed from the front stage to the integrator stage
	typedef struct packed {
		logic signed [PROD_W-1:0] p;
		logic signed [PROD_W-1:0] i;
		logic signed [PROD_W-1:0] d;
		logic                     i_en;
	} prod_t;

endpackage

`default_nettype wire

FILE: hdl/fixed_point_pid_step_top.sv
// Top level of the fixed-point PID step: handshake, configuration and stage control.
//
// Channel   Handshake              Payload              Per transfer
// input     in_valid / in_ready    setpoint, feedback   one sample
// output    out_valid / out_ready  drive                one result
// config    wr_en, wr_index        wr_data              one register write
//
// One sample is taken every cycle while the output is not stalled; a result passes
// the input, product, sum and drive registers in turn. The integrator loop, one
// saturating add per cycle, sets that rate. Reset returns the configuration to its
// defaults and clears the integral and the derivative history.
// Each stage holds while the next one is full, so a stall at the output fills the
// stages one by one before in_ready falls, and empty stages close up.
`default_nettype none

module fixed_point_pid_step_top #(
	parameter int unsigned FRAC_BITS = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [fpps_pkg::DATA_W-1:0]     setpoint,
	input  wire logic signed [fpps_pkg::DATA_W-1:0]     feedback,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [fpps_pkg::DATA_W-1:0]          drive,
	input  wire logic                                   wr_en,
	input  wire logic [fpps_pkg::IDX_W-1:0]             wr_index,
	input  wire logic [fpps_pkg::LIMIT_W-1:0]           wr_data
);

	fpps_pkg::cfg_t                       cfg_q;
	logic signed [fpps_pkg::DATA_W-1:0]   sp_s1;
	logic signed [fpps_pkg::DATA_W-1:0]   fb_s1;
	logic                                 vld_s1;
	logic                                 vld_s2;
	logic                                 vld_s3;
	logic                                 free_q;
	logic                                 free_s3;
	logic                                 free_s2;
	logic                                 adv_s1;
	logic                                 adv_s2;
	logic                                 adv_s3;
	logic                                 in_xfer;
	fpps_pkg::prod_t                      prod_s2;
	logic signed [fpps_pkg::SUM_W-1:0]    sum_s3;

	// Stage control: a stage may load when it is empty or its item moves on.
	assign free_q   = !out_valid || out_ready;
	assign adv_s3   = vld_s3 && free_q;
	assign free_s3  = !vld_s3 || free_q;
	assign adv_s2   = vld_s2 && free_s3;
	assign free_s2  = !vld_s2 || free_s3;
	assign adv_s1   = vld_s1 && free_s2;
	assign in_ready = !vld_s1 || free_s2;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (free_s2) begin
				vld_s2 <= vld_s1;
			end
			if (free_s3) begin
				vld_s3 <= vld_s2;
			end
			if (free_q) begin
				out_valid <= vld_s3;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sp_s1 <= setpoint;
			fb_s1 <= feedback;
		end
	end

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_gain  <= '0;
			cfg_q.i_gain  <= '0;
			cfg_q.d_gain  <= '0;
			cfg_q.out_max <= fpps_pkg::OUT_MAX_RST;
			cfg_q.out_min <= fpps_pkg::OUT_MIN_RST;
		end else if (wr_en) begin
			case (fpps_pkg::reg_idx_t'(wr_index))
				fpps_pkg::REG_P_GAIN: begin
					cfg_q.p_gain <= wr_data[fpps_pkg::GAIN_W-1:0];
				end
				fpps_pkg::REG_I_GAIN: begin
					cfg_q.i_gain <= wr_data[fpps_pkg::GAIN_W-1:0];
				end
				fpps_pkg::REG_D_GAIN: begin
					cfg_q.d_gain <= wr_data[fpps_pkg::GAIN_W-1:0];
				end
				fpps_pkg::REG_OUT_MAX: begin
					cfg_q.out_max <= wr_data;
				end
				fpps_pkg::REG_OUT_MIN: begin
					cfg_q.out_min <= wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath stages.
	fpps_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv_s1),
		.sp      (sp_s1),
		.fb      (fb_s1),
		.cfg     (cfg_q),
		.prod_s2 (prod_s2)
	);

	fpps_integ u_integ (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv_s2),
		.prod_s2 (prod_s2),
		.sum_s3  (sum_s3)
	);

	fpps_round #(
		.FRAC_BITS (FRAC_BITS)
	) u_round (
		.clk     (clk),
		.adv     (adv_s3),
		.sum_s3  (sum_s3),
		.cfg     (cfg_q),
		.drive_q (drive)
	);

	// A ready output frees every stage, so the input must be ready too.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input not ready while output is ready");

	// With every stage full and the output stalled, no sample may enter.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && vld_s3 && out_valid && !out_ready) |-> !in_ready)
		else $error("sample taken while the pipeline is full");

	// An accepted sample occupies the input stage on the next cycle.
	a_input_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> vld_s1)
		else $error("accepted sample lost at the input stage");

	// A result leaving the last stage must show at the output.
	a_output_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s3 |=> out_valid)
		else $error("result lost at the output register");

endmodule

`default_nettype wire

FILE: hdl/fpps_front.sv
// Front stage: error, derivative step and the three gain products.
`default_nettype none

module fpps_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 adv,
	input  wire logic signed [fpps_pkg::DATA_W-1:0]   sp,
	input  wire logic signed [fpps_pkg::DATA_W-1:0]   fb,
	input  wire fpps_pkg::cfg_t                       cfg,
	output fpps_pkg::prod_t                           prod_s2
);

	localparam logic signed [18:0] DV_MAX = 19'sd32767;
	localparam logic signed [18:0] DV_MIN = -19'sd32768;

	logic signed [fpps_pkg::ERR_W-1:0]  err;
	logic signed [fpps_pkg::ERR_W-1:0]  prev_err_q;
	logic signed [fpps_pkg::DATA_W-1:0] prev_sp_q;
	logic signed [17:0]                 err_step;
	logic signed [16:0]                 sp_step;
	logic signed [18:0]                 dv;
	logic signed [15:0]                 dv_sat;
	logic signed [16:0]                 pg_s;
	logic signed [16:0]                 ig_s;
	logic signed [16:0]                 dg_s;
	logic signed [fpps_pkg::PROD_W-1:0] p_prod;
	logic signed [fpps_pkg::PROD_W-1:0] i_prod;
	logic signed [fpps_pkg::PROD_W-1:0] d_prod;

	// Error and the change in error less the change in setpoint.
	assign err      = {sp[15], sp} - {fb[15], fb};
	assign err_step = {err[16], err} - {prev_err_q[16], prev_err_q};
	assign sp_step  = {sp[15], sp} - {prev_sp_q[15], prev_sp_q};
	assign dv       = {err_step[17], err_step} - {{2{sp_step[16]}}, sp_step};

	// The derivative step saturates to the sample range.
	always_comb begin
		if (dv > DV_MAX) begin
			dv_sat = 16'sh7FFF;
		end else if (dv < DV_MIN) begin
			dv_sat = 16'sh8000;
		end else begin
			dv_sat = dv[15:0];
		end
	end

	// Gains are unsigned; a zero gain gives a zero product by itself.
	assign pg_s   = {1'b0, cfg.p_gain};
	assign ig_s   = {1'b0, cfg.i_gain};
	assign dg_s   = {1'b0, cfg.d_gain};
	assign p_prod = pg_s * err;
	assign i_prod = ig_s * err;
	assign d_prod = dg_s * dv_sat;

	// Product register towards the integrator stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2.p    <= p_prod;
			prod_s2.i    <= i_prod;
			prod_s2.d    <= d_prod;
			prod_s2.i_en <= |cfg.i_gain;
		end
	end

	// Derivative history moves only while the derivative gain is in use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sp_q  <= '0;
			prev_err_q <= '0;
		end else if (adv && (|cfg.d_gain)) begin
			prev_sp_q  <= sp;
			prev_err_q <= err;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/fpps_integ.sv
// Integrator stage: saturating accumulate and the sum of the three terms.
`default_nettype none

module fpps_integ (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  adv,
	input  wire fpps_pkg::prod_t                       prod_s2,
	output logic signed [fpps_pkg::SUM_W-1:0]          sum_s3
);

	localparam logic signed [34:0] ACC_MAX = 35'sd2147483647;
	localparam logic signed [34:0] ACC_MIN = -35'sd2147483648;

	logic signed [fpps_pkg::INTEG_W-1:0] integ_q;
	logic signed [34:0]                  acc;
	logic signed [fpps_pkg::INTEG_W-1:0] integ_sat;
	logic signed [fpps_pkg::INTEG_W-1:0] i_term;
	logic signed [fpps_pkg::SUM_W-1:0]   sum;

	// New integral value, saturated to the 32-bit range.
	assign acc = {{3{integ_q[31]}}, integ_q} + {prod_s2.i[33], prod_s2.i};

	always_comb begin
		if (acc > ACC_MAX) begin
			integ_sat = 32'sh7FFFFFFF;
		end else if (acc < ACC_MIN) begin
			integ_sat = 32'sh80000000;
		end else begin
			integ_sat = acc[31:0];
		end
	end

	// The integral term counts only while its gain is nonzero.
	assign i_term = prod_s2.i_en ? integ_sat : '0;
	assign sum    = {{2{prod_s2.p[33]}}, prod_s2.p}
	              + {{4{i_term[31]}}, i_term}
	              + {{2{prod_s2.d[33]}}, prod_s2.d};

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= sum;
		end
	end

	// Accumulator state, held while the integral gain is zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (adv && prod_s2.i_en) begin
			integ_q <= integ_sat;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/fpps_round.sv
// Output stage: window clamp, rounding shift and saturation to 16 bits.
`default_nettype none

module fpps_round #(
	parameter int unsigned FRAC_BITS = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  adv,
	input  wire logic signed [fpps_pkg::SUM_W-1:0]     sum_s3,
	input  wire fpps_pkg::cfg_t                        cfg,
	output logic signed [fpps_pkg::DATA_W-1:0]         drive_q
);

	localparam logic signed [24:0] Q_MAX = 25'sd32767;
	localparam logic signed [24:0] Q_MIN = -25'sd32768;

	logic signed [fpps_pkg::SUM_W-1:0]   max_x;
	logic signed [fpps_pkg::SUM_W-1:0]   min_x;
	logic signed [fpps_pkg::LIMIT_W-1:0] win;
	logic signed [24:0]                  win_x;
	logic signed [24:0]                  shifted;
	logic signed [24:0]                  q;
	logic signed [fpps_pkg::DATA_W-1:0]  q_sat;

	assign max_x = {{12{cfg.out_max[23]}}, cfg.out_max};
	assign min_x = {{12{cfg.out_min[23]}}, cfg.out_min};

	// Upper limit is tested first, so an inverted window favours out_max.
	always_comb begin
		if (sum_s3 > max_x) begin
			win = cfg.out_max;
		end else if (sum_s3 < min_x) begin
			win = cfg.out_min;
		end else begin
			win = sum_s3[23:0];
		end
	end

	// Floor shift, then round up when the half bit is set.
	assign win_x   = {win[23], win};
	assign shifted = win_x >>> FRAC_BITS;
	assign q       = shifted + {24'b0, win[FRAC_BITS-1]};

	always_comb begin
		if (q > Q_MAX) begin
			q_sat = 16'sh7FFF;
		end else if (q < Q_MIN) begin
			q_sat = 16'sh8000;
		end else begin
			q_sat = q[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_q <= q_sat;
		end
	end

endmodule

`default_nettype wire

FILE: verif/fixed_point_pid_step_top_tb.sv
// Self-checking testbench for the fixed-point PID step with clocked driver, monitor, predictor.
`timescale 1ns / 100ps

module fixed_point_pid_step_top_tb;

	localparam int FRAC_BITS     = 8;
	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 5;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;
	localparam int QUIET_LIMIT   = 5000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_SAMPLES = 150;

	// Register indexes that decode to nothing
	localparam logic [fpps_pkg::IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [fpps_pkg::IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	localparam longint INTEGRAL_HI = 64'sd2147483647;
	localparam longint INTEGRAL_LO = -64'sd2147483648;
	localparam longint DRIVE_MAX   = 64'sd32767;
	localparam longint DRIVE_MIN   = -64'sd32768;

	typedef struct {
		logic signed [fpps_pkg::DATA_W-1:0] sp;
		logic signed [fpps_pkg::DATA_W-1:0] fb;
	} sample_t;

	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic                               in_valid  = 1'b0;
	logic                               in_ready;
	logic signed [fpps_pkg::DATA_W-1:0] setpoint  = '0;
	logic signed [fpps_pkg::DATA_W-1:0] feedback  = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic signed [fpps_pkg::DATA_W-1:0] drive;
	logic                               wr_en     = 1'b0;
	logic [fpps_pkg::IDX_W-1:0]         wr_index  = fpps_pkg::REG_P_GAIN;
	logic [fpps_pkg::LIMIT_W-1:0]       wr_data   = '0;

	// Predictor copy of the registers and the controller state
	longint kp, ki, kd, win_hi, win_lo;
	longint integ_acc, last_sp, last_err;

	sample_t                            pending_samples[$];
	logic signed [fpps_pkg::DATA_W-1:0] drive_expected[$];
	logic signed [fpps_pkg::DATA_W-1:0] target = '0;

	int mismatches     = 0;
	int samples_sent   = 0;
	int drives_checked = 0;
	int settings_used  = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int quiet_cycles   = 0;

	fixed_point_pid_step_top #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.setpoint(setpoint),
		.feedback(feedback),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive(drive),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	// One controller step: updates the integral and derivative history, returns the drive.
	function automatic logic signed [fpps_pkg::DATA_W-1:0] compute_drive(
		input logic signed [fpps_pkg::DATA_W-1:0] sp,
		input logic signed [fpps_pkg::DATA_W-1:0] fb
	);
		longint err, p_term, i_term, d_term, slope, total, q;
		err    = longint'(sp) - longint'(fb);
		p_term = kp * err;
		i_term = 0;
		d_term = 0;
		if (ki != 0) begin
			integ_acc = integ_acc + err * ki;
			if (integ_acc > INTEGRAL_HI)
				integ_acc = INTEGRAL_HI;
			else if (integ_acc < INTEGRAL_LO)
				integ_acc = INTEGRAL_LO;
			i_term = integ_acc;
		end
		// The history only moves while the derivative gain is in use.
		if (kd != 0) begin
			slope    = (err - last_err) - (longint'(sp) - last_sp);
			last_sp  = sp;
			last_err = err;
			if (slope > DRIVE_MAX)
				slope = DRIVE_MAX;
			else if (slope < DRIVE_MIN)
				slope = DRIVE_MIN;
			d_term = kd * slope;
		end
		// The upper bound is tested first, which matters for an inverted window.
		total = p_term + i_term + d_term;
		if (total > win_hi)
			total = win_hi;
		else if (total < win_lo)
			total = win_lo;
		q = total >>> FRAC_BITS;
		if (total[FRAC_BITS-1])
			q = q + 1;
		if (q > DRIVE_MAX)
			q = DRIVE_MAX;
		else if (q < DRIVE_MIN)
			q = DRIVE_MIN;
		return q[fpps_pkg::DATA_W-1:0];
	endfunction

	task automatic write_register(
		input logic [fpps_pkg::IDX_W-1:0]   idx,
		input logic [fpps_pkg::LIMIT_W-1:0] data
	);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
			fpps_pkg::REG_P_GAIN:  kp = data[fpps_pkg::GAIN_W-1:0];
			fpps_pkg::REG_I_GAIN:  ki = data[fpps_pkg::GAIN_W-1:0];
			fpps_pkg::REG_D_GAIN:  kd = data[fpps_pkg::GAIN_W-1:0];
			fpps_pkg::REG_OUT_MAX: win_hi = $signed(data);
			fpps_pkg::REG_OUT_MIN: win_lo = $signed(data);
			default:               ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Waits until no sample is queued or in flight, then lets the pipeline run dry.
	task automatic settle(input int extra);
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || in_valid || drive_expected.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	// Writes every register once the block is idle; gain writes carry junk in the upper bits.
	task automatic apply_settings(
		input logic [fpps_pkg::GAIN_W-1:0]  p,
		input logic [fpps_pkg::GAIN_W-1:0]  i,
		input logic [fpps_pkg::GAIN_W-1:0]  d,
		input logic [fpps_pkg::LIMIT_W-1:0] hi,
		input logic [fpps_pkg::LIMIT_W-1:0] lo
	);
		settle(SETTLE_CYCLES);
		write_register(fpps_pkg::REG_P_GAIN,
			{(fpps_pkg::LIMIT_W-fpps_pkg::GAIN_W)'($urandom), p});
		write_register(fpps_pkg::REG_I_GAIN,
			{(fpps_pkg::LIMIT_W-fpps_pkg::GAIN_W)'($urandom), i});
		write_register(fpps_pkg::REG_D_GAIN,
			{(fpps_pkg::LIMIT_W-fpps_pkg::GAIN_W)'($urandom), d});
		write_register(fpps_pkg::REG_OUT_MAX, hi);
		write_register(fpps_pkg::REG_OUT_MIN, lo);
		write_register(fpps_pkg::IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
			fpps_pkg::LIMIT_W'($urandom));
		settings_used++;
	endtask

	task automatic queue_sample(
		input logic signed [fpps_pkg::DATA_W-1:0] sp,
		input logic signed [fpps_pkg::DATA_W-1:0] fb
	);
		sample_t s;
		s.sp = sp;
		s.fb = fb;
		pending_samples.push_back(s);
	endtask

	function automatic logic signed [fpps_pkg::DATA_W-1:0] extreme_value();
		case ($urandom_range(4))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return 16'sh0000;
			3:       return 16'sh0001;
			default: return 16'shFFFF;
		endcase
	endfunction

	function automatic logic [fpps_pkg::GAIN_W-1:0] random_gain();
		case ($urandom_range(5))
			0:       return '0;
			1:       return '1;
			2, 3:    return fpps_pkg::GAIN_W'($urandom_range(512));
			default: return fpps_pkg::GAIN_W'($urandom);
		endcase
	endfunction

	// Mostly a target that jumps at times, tracked closely; full-scale and extremes mixed in.
	task automatic queue_random_sample();
		int near;
		case ($urandom_range(9))
			0, 1: queue_sample(extreme_value(), extreme_value());
			2, 3: queue_sample(fpps_pkg::DATA_W'($urandom), fpps_pkg::DATA_W'($urandom));
			default: begin
				if ($urandom_range(3) == 0)
					target = fpps_pkg::DATA_W'($urandom);
				near = int'(target) + int'($urandom_range(600)) - 300;
				if (near > DRIVE_MAX)
					near = DRIVE_MAX;
				else if (near < DRIVE_MIN)
					near = DRIVE_MIN;
				queue_sample(target, near[fpps_pkg::DATA_W-1:0]);
			end
		endcase
	endtask

	// Sender: a transfer at this edge is predicted, then the next sample may be offered.
	always @(posedge clk) begin : sender
		sample_t nxt;
		if (in_valid && in_ready) begin
			drive_expected.push_back(compute_drive(setpoint, feedback));
			samples_sent++;
		end
		if (!in_valid || in_ready) begin
			if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_samples.pop_front();
				in_valid <= 1'b1;
				setpoint <= nxt.sp;
				feedback <= nxt.fb;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: each output transfer is checked against the oldest prediction.
	always @(posedge clk) begin : receiver
		logic signed [fpps_pkg::DATA_W-1:0] want;
		if (out_valid && out_ready) begin
			drives_checked++;
			if (drive_expected.size() == 0) begin
				report_mismatch($sformatf("drive %0d arrived with no sample outstanding", drive));
			end else begin
				want = drive_expected.pop_front();
				if (drive !== want)
					report_mismatch($sformatf("drive got %0d, expected %0d", drive, want));
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Ends the run when no transfer has happened on either side for too long.
	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timed out after %0d cycles without a transfer.", quiet_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : stimulus
		logic [fpps_pkg::LIMIT_W-1:0] hi, lo;
		int unsigned                  span;

		kp        = 0;
		ki        = 0;
		kd        = 0;
		win_hi    = fpps_pkg::OUT_MAX_RST;
		win_lo    = fpps_pkg::OUT_MIN_RST;
		integ_acc = 0;
		last_sp   = 0;
		last_err  = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// All gains are zero after reset, so even full-scale error drives nothing.
		queue_sample(16'sh7FFF, 16'sh8000);
		queue_sample(16'sh8000, 16'sh7FFF);

		// Unity proportional gain: clamping at both window edges and small values.
		apply_settings(16'd256, 16'd0, 16'd0, fpps_pkg::OUT_MAX_RST, fpps_pkg::OUT_MIN_RST);
		queue_sample(16'sh7FFF, 16'sh8000);
		queue_sample(16'sh8000, 16'sh7FFF);
		queue_sample(16'sh0000, 16'sh0000);
		queue_sample(16'sh0001, 16'sh0000);
		queue_sample(16'shFFFF, 16'sh0000);

		// Half gain puts the error on the rounding bit.
		apply_settings(16'd128, 16'd0, 16'd0, fpps_pkg::OUT_MAX_RST, fpps_pkg::OUT_MIN_RST);
		queue_sample(16'sh0001, 16'sh0000);
		queue_sample(16'shFFFF, 16'sh0000);
		queue_sample(16'sh0003, 16'sh0000);

		// Full 24-bit window: rounding past the top of the drive range saturates.
		apply_settings(16'hFFFF, 16'd0, 16'd0, 24'h7FFFFF, 24'h800000);
		queue_sample(16'sh7FFF, 16'sh8000);
		queue_sample(16'sh8000, 16'sh7FFF);
		queue_sample(16'sh0001, 16'sh0000);

		// Integral alone, driven into both saturation limits.
		apply_settings(16'd0, 16'hFFFF, 16'd0, 24'h7FFFFF, 24'h800000);
		queue_sample(16'sh7FFF, 16'sh8000);
		queue_sample(16'sh7FFF, 16'sh8000);
		queue_sample(16'sh7FFF, 16'sh8000);
		queue_sample(16'sh8000, 16'sh7FFF);
		queue_sample(16'sh8000, 16'sh7FFF);

		// Derivative alone with the integral held.
		apply_settings(16'd0, 16'd0, 16'hFFFF, 24'h7FFFFF, 24'h800000);
		queue_sample(16'sd100, 16'sd0);
		queue_sample(16'sd100, 16'sd50);
		queue_sample(16'sh8000, 16'sh7FFF);

		// With the derivative gain cleared the history must stay put.
		settle(SETTLE_CYCLES);
		write_register(fpps_pkg::REG_D_GAIN, '0);
		queue_sample(16'sd5, 16'sd5);

		// Inverted window: the upper bound wins whenever the sum exceeds it.
		apply_settings(16'd256, 16'd0, 16'd0, -24'sd1000, 24'sd1000);
		queue_sample(16'sh0000, 16'sh0000);
		queue_sample(16'sd100, 16'sh0000);

		// Random phases, each with its own settings and idling mix.
		for (int k = 0; k < RANDOM_PHASES; k++) begin
			if (k == 0) begin
				apply_settings('1, '1, '1, 24'h7FFFFF, 24'h800000);
			end else begin
				case ($urandom_range(4))
					0: begin
						hi = 24'h7FFFFF;
						lo = 24'h800000;
					end
					1: begin
						hi = fpps_pkg::OUT_MAX_RST;
						lo = fpps_pkg::OUT_MIN_RST;
					end
					2: begin
						hi = fpps_pkg::LIMIT_W'($urandom);
						lo = fpps_pkg::LIMIT_W'($urandom);
					end
					default: begin
						span = $urandom_range(24'h7FFFFF, 1);
						hi   = fpps_pkg::LIMIT_W'(span);
						lo   = fpps_pkg::LIMIT_W'(-span);
					end
				endcase
				apply_settings(random_gain(), random_gain(), random_gain(), hi, lo);
			end
			case (k % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 87;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 87;
				end
				default: begin
					send_idle_pct  = 6;
					recv_stall_pct = 6;
				end
			endcase
			repeat (PHASE_SAMPLES) queue_random_sample();
		end

		settle(TAIL_CYCLES);
		if (drive_expected.size() != 0)
			report_mismatch($sformatf("%0d drive values never arrived", drive_expected.size()));
		$display("Ran %0d samples over %0d gain and window settings, directed extremes first.",
			samples_sent, settings_used);
		$display("Compared %0d drive values under idling from none to 87 in a hundred cycles.",
			drives_checked);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/fpps_pkg.sv
hdl/fpps_front.sv
hdl/fpps_integ.sv
hdl/fpps_round.sv
hdl/fixed_point_pid_step_top.sv
verif/fixed_point_pid_step_top_tb.sv
